// File: hw/rtl/dsg_pkg.sv
`default_nettype none

package dsg_pkg;

    localparam int OPERAND_W = 32;
    localparam int SCALE_W   = 16;
    localparam int LOAD_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    typedef enum logic [2:0] {
        OP_ADD_LOAD  = 3'd0,
        OP_SET_LOAD  = 3'd1,
        OP_ADJUST    = 3'd2,
        OP_RESTART   = 3'd3,
        OP_COUNT_EN  = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        DIR_STEADY = 2'd0,
        DIR_DOWN   = 2'd1,
        DIR_UP     = 2'd2,
        DIR_FLOOR  = 2'd3
    } t_dir;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_LOAD    = 3'd0,
        CFG_LOAD_TOLERANCE = 3'd1,
        CFG_STEP_SIZE      = 3'd2,
        CFG_MIN_SCALE      = 3'd3,
        CFG_MAX_SCALE      = 3'd4,
        CFG_IDEAL_SCALE    = 3'd5,
        CFG_GOVERNOR_OFF   = 3'd6
    } t_cfg_idx;

    localparam logic [31:0]        RST_TARGET_LOAD    = 32'd2000;
    localparam logic [31:0]        RST_LOAD_TOLERANCE = 32'd350;
    localparam logic [SCALE_W-1:0] RST_STEP_SIZE      = 16'd33;
    localparam logic [SCALE_W-1:0] RST_MIN_SCALE      = 16'd819;
    localparam logic [SCALE_W-1:0] RST_MAX_SCALE      = 16'd4915;
    localparam logic [SCALE_W-1:0] RST_IDEAL_SCALE    = 16'd4096;

endpackage

`default_nettype wire

// File: hw/rtl/dsg_in_if.sv
`default_nettype none

interface dsg_in_if;
    logic                           valid;
    logic                           ready;
    logic [2:0]                     opcode;
    logic [dsg_pkg::OPERAND_W-1:0]  operand_value;

    modport source (output valid, output opcode, output operand_value, input ready);
    modport sink   (input valid, input opcode, input operand_value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dsg_out_if.sv
`default_nettype none

interface dsg_out_if;
    logic                           valid;
    logic                           ready;
    logic [dsg_pkg::SCALE_W-1:0]    scale_now;
    logic                           panic_flag;
    logic [dsg_pkg::LOAD_W-1:0]     load_now;
    logic [1:0]                     direction;

    modport source (output valid, output scale_now, output panic_flag,
                    output load_now, output direction, input ready);
    modport sink   (input valid, input scale_now, input panic_flag,
                    input load_now, input direction, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/detail_scale_governor.sv
`default_nettype none

// Load governor: accumulates a per-frame load count and, on each adjust
// transaction, steps an unsigned Q4.12 scale factor down or up by one, two or
// four times step_size depending on how far the count lies from target_load
// in units of load_tolerance, with hysteresis, a floor mark and a panic flag.
// Every input transaction returns exactly one result carrying the state after
// it. One transaction is accepted every cycle while the result is not stalled;
// a result passes through the input register, then the state registers, which
// double as the result register. A stalled result holds the input register
// and drops input ready. The adjust path of 32-bit compares and one add/clamp
// sits between those two registers. The load count is COUNT_BITS wide and
// saturates at its maximum; load_now shows it zero-extended. Configuration
// writes take effect at once and belong in idle periods.
module detail_scale_governor #(
    parameter int COUNT_BITS = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    dsg_in_if.sink                           i_in,
    dsg_out_if.source                        o_out,
    input  wire                              i_cfg_we,
    input  wire [dsg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [dsg_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    localparam int SW = dsg_pkg::SCALE_W;
    localparam logic [32:0] CNT_MAX = 33'((34'd1 << COUNT_BITS) - 34'd1);

    // configuration
    logic [31:0]   r_target_load;
    logic [31:0]   r_load_tolerance;
    logic [SW-1:0] r_step_size;
    logic [SW-1:0] r_min_scale;
    logic [SW-1:0] r_max_scale;
    logic [SW-1:0] r_ideal_scale;
    logic          r_governor_off;

    // input register
    logic          r_in_vld;
    logic [2:0]    r_op;
    logic [31:0]   r_val;

    // state, also the result register
    logic                  r_out_vld;
    logic [SW-1:0]         r_scale;
    logic [COUNT_BITS-1:0] r_load;
    dsg_pkg::t_dir         r_dir;
    logic                  r_panic;
    logic                  r_count_en;

    logic [SW-1:0]         n_scale;
    logic [COUNT_BITS-1:0] n_load;
    dsg_pkg::t_dir         n_dir;
    logic                  n_panic;
    logic                  n_count_en;

    logic advance;
    logic process;

    assign advance = !r_out_vld || o_out.ready;
    assign process = r_in_vld && advance;
    assign i_in.ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_load    <= dsg_pkg::RST_TARGET_LOAD;
            r_load_tolerance <= dsg_pkg::RST_LOAD_TOLERANCE;
            r_step_size      <= dsg_pkg::RST_STEP_SIZE;
            r_min_scale      <= dsg_pkg::RST_MIN_SCALE;
            r_max_scale      <= dsg_pkg::RST_MAX_SCALE;
            r_ideal_scale    <= dsg_pkg::RST_IDEAL_SCALE;
            r_governor_off   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dsg_pkg::CFG_TARGET_LOAD:    r_target_load    <= i_cfg_data;
                dsg_pkg::CFG_LOAD_TOLERANCE: r_load_tolerance <= i_cfg_data;
                dsg_pkg::CFG_STEP_SIZE:      r_step_size      <= i_cfg_data[SW-1:0];
                dsg_pkg::CFG_MIN_SCALE:      r_min_scale      <= i_cfg_data[SW-1:0];
                dsg_pkg::CFG_MAX_SCALE:      r_max_scale      <= i_cfg_data[SW-1:0];
                dsg_pkg::CFG_IDEAL_SCALE:    r_ideal_scale    <= i_cfg_data[SW-1:0];
                dsg_pkg::CFG_GOVERNOR_OFF:   r_governor_off   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_op  <= i_in.opcode;
            r_val <= i_in.operand_value;
        end
    end

    // next-state logic
    logic [32:0]   cnt33;
    logic [32:0]   val33;
    logic [32:0]   sum33;
    logic [31:0]   cnt;
    logic          inactive;
    logic          cnt_gt_tgt;
    logic [31:0]   span;
    logic [32:0]   tgt_tol;
    logic [32:0]   tol2;
    logic          d_gt_tol;
    logic          d_gt_2tol;
    logic [SW+1:0] stp;
    logic [SW+1:0] dn_scale;
    logic [SW+2:0] up_scale;

    always_comb begin
        cnt33      = 33'(r_load);
        val33      = {1'b0, r_val};
        sum33      = cnt33 + val33;
        cnt        = 32'(r_load);
        inactive   = (r_target_load == '0) || (r_load_tolerance == '0) || r_governor_off;
        cnt_gt_tgt = cnt > r_target_load;
        span       = cnt_gt_tgt ? (cnt - r_target_load) : (r_target_load - cnt);
        tgt_tol    = {1'b0, r_target_load} + {1'b0, r_load_tolerance};
        tol2       = {r_load_tolerance, 1'b0};
        d_gt_tol   = span > r_load_tolerance;
        d_gt_2tol  = {1'b0, span} > tol2;

        if (d_gt_2tol) begin
            stp = {r_step_size, 2'b00};
        end else if (d_gt_tol || !cnt_gt_tgt) begin
            stp = {1'b0, r_step_size, 1'b0};
        end else begin
            stp = {2'b00, r_step_size};
        end

        // saturate at zero before the floor clamp
        dn_scale = ({2'b00, r_scale} > stp) ? ({2'b00, r_scale} - stp) : '0;
        up_scale = {3'b000, r_scale} + {1'b0, stp};

        n_scale    = r_scale;
        n_load     = r_load;
        n_dir      = r_dir;
        n_panic    = r_panic;
        n_count_en = r_count_en;

        case (r_op)
            dsg_pkg::OP_ADD_LOAD: begin
                if (r_count_en) begin
                    n_load = COUNT_BITS'((sum33 > CNT_MAX) ? CNT_MAX : sum33);
                end
            end
            dsg_pkg::OP_SET_LOAD: begin
                n_load = COUNT_BITS'((val33 > CNT_MAX) ? CNT_MAX : val33);
            end
            dsg_pkg::OP_ADJUST: begin
                n_panic = 1'b0;
                if (inactive) begin
                    n_scale = r_max_scale;
                end else if (cnt_gt_tgt) begin
                    // hold while rising and still inside the band
                    if (!(r_dir == dsg_pkg::DIR_UP && {1'b0, cnt} < tgt_tol)) begin
                        if (dn_scale < {2'b00, r_min_scale}) begin
                            n_scale = r_min_scale;
                            n_dir   = dsg_pkg::DIR_FLOOR;
                            n_panic = {1'b0, cnt} > tgt_tol;
                        end else begin
                            n_scale = dn_scale[SW-1:0];
                            n_dir   = dsg_pkg::DIR_DOWN;
                        end
                    end
                end else if (d_gt_tol) begin
                    n_dir   = dsg_pkg::DIR_UP;
                    n_scale = (up_scale > {3'b000, r_max_scale}) ? r_max_scale
                                                                 : up_scale[SW-1:0];
                end
            end
            dsg_pkg::OP_RESTART: begin
                n_scale    = r_ideal_scale;
                n_dir      = dsg_pkg::DIR_STEADY;
                n_panic    = 1'b0;
                n_count_en = 1'b1;
            end
            dsg_pkg::OP_COUNT_EN: begin
                n_count_en = r_val[0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_scale    <= dsg_pkg::RST_IDEAL_SCALE;
            r_load     <= '0;
            r_dir      <= dsg_pkg::DIR_STEADY;
            r_panic    <= 1'b0;
            r_count_en <= 1'b1;
        end else begin
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
            if (process) begin
                r_scale    <= n_scale;
                r_load     <= n_load;
                r_dir      <= n_dir;
                r_panic    <= n_panic;
                r_count_en <= n_count_en;
            end
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.scale_now  = r_scale;
    assign o_out.panic_flag = r_panic;
    assign o_out.load_now   = dsg_pkg::LOAD_W'(r_load);
    assign o_out.direction  = r_dir;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dsg_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned PHASES        = 12;
    localparam int unsigned PHASE_ITEMS   = 140;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam logic [LOAD_W-1:0]   LOAD_CEIL  = {LOAD_W{1'b1}};

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic               panic;
        logic [LOAD_W-1:0]  load;
        logic [1:0]         dir;
    } t_reading;

    // raw write data, upper bits of the narrow registers may carry junk
    typedef struct {
        logic [CFG_DAT_W-1:0] target, tol, step, min_s, max_s, ideal, off;
    } t_gov_cfg;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    dsg_in_if  gov_in();
    dsg_out_if gov_out();

    detail_scale_governor #(.COUNT_BITS(32)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (gov_in),
        .o_out      (gov_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // governor registers and state as the testbench sees them
    logic [31:0]        gov_target, gov_tol;
    logic [SCALE_W-1:0] gov_step, gov_min, gov_max, gov_ideal;
    logic               gov_off;
    logic [SCALE_W-1:0] gov_scale;
    logic [LOAD_W-1:0]  gov_load;
    t_dir               gov_dir;
    logic               gov_panic;
    logic               gov_count_en;

    t_reading    pending_readings[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          feed_gaps_on = 1'b1;
    bit          drain_stalls_on = 1'b1;

    function automatic int unsigned draw_gap(bit on);
        if (!on)
            return 0;
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 2);
    endfunction

    function automatic void store_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        case (idx)
            CFG_TARGET_LOAD:    gov_target = data;
            CFG_LOAD_TOLERANCE: gov_tol    = data;
            CFG_STEP_SIZE:      gov_step   = data[SCALE_W-1:0];
            CFG_MIN_SCALE:      gov_min    = data[SCALE_W-1:0];
            CFG_MAX_SCALE:      gov_max    = data[SCALE_W-1:0];
            CFG_IDEAL_SCALE:    gov_ideal  = data[SCALE_W-1:0];
            CFG_GOVERNOR_OFF:   gov_off    = data[0];
            default: ;
        endcase
    endfunction

    function automatic void governor_adjust();
        logic [33:0] cnt, tgt, tol, span, stp, s;
        cnt = {2'd0, gov_load};
        tgt = {2'd0, gov_target};
        tol = {2'd0, gov_tol};
        gov_panic = 1'b0;
        if (tgt == 0 || tol == 0 || gov_off) begin
            gov_scale = gov_max;
        end else begin
            span = (cnt > tgt) ? cnt - tgt : tgt - cnt;
            if (cnt > tgt) begin
                // hold while still climbing and only mildly over target
                if (!(gov_dir == DIR_UP && cnt < tgt + tol)) begin
                    gov_dir = DIR_DOWN;
                    stp = {18'd0, gov_step};
                    if (span > tol) begin
                        stp = stp << 1;
                        if (span > (tol << 1))
                            stp = stp << 1;
                    end
                    s = {18'd0, gov_scale};
                    s = (s > stp) ? s - stp : 34'd0;
                    if (s < {18'd0, gov_min}) begin
                        s = {18'd0, gov_min};
                        gov_dir = DIR_FLOOR;
                        if (cnt > tgt + tol)
                            gov_panic = 1'b1;
                    end
                    gov_scale = s[SCALE_W-1:0];
                end
            end else if (span > tol) begin
                if (cnt + tol < tgt || gov_dir != DIR_FLOOR) begin
                    gov_dir = DIR_UP;
                    stp = {18'd0, gov_step} << ((span > (tol << 1)) ? 2 : 1);
                    s = {18'd0, gov_scale} + stp;
                    if (s > {18'd0, gov_max})
                        s = {18'd0, gov_max};
                    gov_scale = s[SCALE_W-1:0];
                end
            end
        end
    endfunction

    function automatic t_reading governor_step(logic [2:0] op, logic [31:0] val);
        logic [32:0] sum;
        t_reading r;
        case (op)
            OP_ADD_LOAD: begin
                if (gov_count_en) begin
                    sum = {1'b0, gov_load} + {1'b0, val};
                    gov_load = sum[32] ? LOAD_CEIL : sum[31:0];
                end
            end
            OP_SET_LOAD: gov_load = val;
            OP_ADJUST:   governor_adjust();
            OP_RESTART: begin
                gov_scale    = gov_ideal;
                gov_dir      = DIR_STEADY;
                gov_panic    = 1'b0;
                gov_count_en = 1'b1;
            end
            OP_COUNT_EN: gov_count_en = val[0];
            default: ;
        endcase
        r.scale = gov_scale;
        r.panic = gov_panic;
        r.load  = gov_load;
        r.dir   = gov_dir;
        return r;
    endfunction

    function automatic t_gov_cfg reset_cfg();
        t_gov_cfg c;
        c.target = RST_TARGET_LOAD;
        c.tol    = RST_LOAD_TOLERANCE;
        c.step   = {16'd0, RST_STEP_SIZE};
        c.min_s  = {16'd0, RST_MIN_SCALE};
        c.max_s  = {16'd0, RST_MAX_SCALE};
        c.ideal  = {16'd0, RST_IDEAL_SCALE};
        c.off    = 32'd0;
        return c;
    endfunction

    // load a little or a few tolerances away from target, boundaries included
    function automatic logic [31:0] load_near_target();
        logic [35:0] offs, v;
        offs = (36'(gov_tol) * $urandom_range(0, 6)) >> 1;
        case ($urandom_range(0, 3))
            0: offs = offs + 36'd1;
            1: if (offs != 0) offs = offs - 36'd1;
            default: ;
        endcase
        if ($urandom_range(0, 1))
            v = 36'(gov_target) + offs;
        else
            v = (offs > 36'(gov_target)) ? 36'd0 : 36'(gov_target) - offs;
        if ($urandom_range(0, 15) == 0)
            v = 36'($urandom);
        return (v > 36'(LOAD_CEIL)) ? LOAD_CEIL : v[31:0];
    endfunction

    function automatic t_gov_cfg phase_cfg(int unsigned p);
        t_gov_cfg c;
        c = reset_cfg();
        if (p >= 3) begin
            c.target = $urandom_range(1, 200000);
            c.tol    = $urandom_range(1, c.target / 2 + 1);
            c.step   = {16'($urandom), 16'($urandom_range(0, 700))};
            c.min_s  = {16'($urandom), 16'($urandom_range(0, 3000))};
            c.max_s  = {16'($urandom), 16'($urandom_range(2000, 65535))};
            c.ideal  = {16'($urandom), 16'($urandom)};
            c.off    = {31'($urandom), 1'b0};
        end
        case (p)
            1: begin
                c.target = '1; c.tol = '1; c.step = '1;
                c.min_s = '1; c.max_s = '1; c.ideal = '1;
            end
            2: begin
                c.target = 32'd1; c.tol = 32'd1; c.step = 32'd0;
                c.min_s = 32'd0; c.max_s = 32'd0; c.ideal = 32'd0;
            end
            3: c.off = {31'($urandom), 1'b1};
            4: c.target = 32'd0;
            5: c.tol = 32'd0;
            default: ;
        endcase
        return c;
    endfunction

    task automatic send_item(logic [2:0] op, logic [31:0] val);
        int unsigned gap;
        gap = draw_gap(feed_gaps_on);
        if (gap != 0) begin
            gov_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        gov_in.valid         <= 1'b1;
        gov_in.opcode        <= op;
        gov_in.operand_value <= val;
        do @(posedge i_clk); while (gov_in.ready !== 1'b1);
        pending_readings.push_back(governor_step(op, val));
    endtask

    task automatic drain_results();
        gov_in.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        store_setting(idx, data);
    endtask

    task automatic apply_config(t_gov_cfg c);
        drain_results();
        write_reg(CFG_TARGET_LOAD, c.target);
        write_reg(CFG_LOAD_TOLERANCE, c.tol);
        write_reg(CFG_STEP_SIZE, c.step);
        write_reg(CFG_MIN_SCALE, c.min_s);
        write_reg(CFG_MAX_SCALE, c.max_s);
        write_reg(CFG_IDEAL_SCALE, c.ideal);
        write_reg(CFG_GOVERNOR_OFF, c.off);
        write_reg(CFG_SPARE, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_unused_opcodes();
        send_item(3'd5, $urandom);
        send_item(3'd7, $urandom);
    endtask

    task automatic test_load_counting();
        send_item(OP_SET_LOAD, 32'hFFFF_FFF0);
        send_item(OP_ADD_LOAD, 32'hFFFF_FFFF);
        send_item(OP_COUNT_EN, 32'hFFFF_FFFE);
        send_item(OP_ADD_LOAD, 32'd5);
        send_item(OP_SET_LOAD, 32'd1500);
        send_item(OP_COUNT_EN, 32'd1);
        send_item(OP_ADD_LOAD, 32'd0);
    endtask

    task automatic test_adjust_hysteresis();
        send_item(OP_ADJUST, $urandom);
        send_item(OP_SET_LOAD, 32'd2200);
        send_item(OP_ADJUST, $urandom);
        send_item(OP_SET_LOAD, 32'd1800);
        send_item(OP_ADJUST, $urandom);
        send_item(OP_SET_LOAD, 32'd2351);
        send_item(OP_ADJUST, $urandom);
    endtask

    task automatic test_floor_and_panic();
        t_gov_cfg c;
        c = reset_cfg();
        c.step = 32'h0000_FFFF;
        apply_config(c);
        send_item(OP_SET_LOAD, 32'hFFFF_FFFF);
        send_item(OP_ADJUST, $urandom);
        send_item(OP_SET_LOAD, 32'd2100);
        send_item(OP_ADJUST, $urandom);
        send_item(OP_SET_LOAD, 32'd100);
        send_item(OP_ADJUST, $urandom);
    endtask

    task automatic test_restart();
        send_item(OP_COUNT_EN, 32'd0);
        send_item(OP_RESTART, $urandom);
        send_item(OP_ADD_LOAD, 32'd7);
    endtask

    task automatic test_down_step_above_max();
        t_gov_cfg c;
        c = reset_cfg();
        c.ideal = 32'hABCD_FFFF;
        c.max_s = 32'd100;
        c.min_s = 32'd0;
        c.step  = 32'h5A5A_0064;
        apply_config(c);
        send_item(OP_RESTART, $urandom);
        send_item(OP_SET_LOAD, 32'hFFFF_FFFF);
        send_item(OP_ADJUST, $urandom);
        // step past zero with a zero floor: saturate, no floor mark
        c.step = 32'h0000_FFFF;
        apply_config(c);
        send_item(OP_ADJUST, $urandom);
    endtask

    task automatic test_inactive_governor();
        t_gov_cfg c;
        c = reset_cfg();
        c.off   = 32'hFFFF_FFFF;
        c.max_s = 32'h0000_FFFF;
        apply_config(c);
        send_item(OP_ADJUST, $urandom);
        c = reset_cfg();
        c.target = 32'd0;
        apply_config(c);
        send_item(OP_ADJUST, $urandom);
        c = reset_cfg();
        c.tol = 32'd0;
        apply_config(c);
        send_item(OP_ADJUST, $urandom);
    endtask

    task automatic test_random_frames();
        int unsigned sent, r;
        logic [31:0] v, part;
        logic [2:0]  op;
        for (int unsigned p = 0; p < PHASES; p++) begin
            apply_config(phase_cfg(p));
            send_item(OP_RESTART, $urandom);
            sent = 1;
            while (sent < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    op = 3'($urandom);
                    send_item(op, $urandom);
                    if (op <= OP_COUNT_EN)
                        sent++;
                end else if (r < 11) begin
                    send_item(OP_RESTART, $urandom);
                    sent++;
                end else if (r < 14) begin
                    send_item(OP_COUNT_EN, $urandom);
                    sent++;
                end else if (r < 15) begin
                    drain_results();
                end else if (r < 18) begin
                    feed_gaps_on    = $urandom_range(0, 1);
                    drain_stalls_on = $urandom_range(0, 1);
                end else begin
                    // one frame: build up the load, then adjust
                    v = load_near_target();
                    if ($urandom_range(0, 2) == 0) begin
                        part = $urandom_range(0, v);
                        send_item(OP_SET_LOAD, part);
                        send_item(OP_ADD_LOAD, v - part);
                        sent += 2;
                    end else begin
                        send_item(OP_SET_LOAD, v);
                        sent++;
                    end
                    repeat ($urandom_range(1, 2)) begin
                        send_item(OP_ADJUST, $urandom);
                        sent++;
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : result_sink
        int unsigned stall;
        t_reading got, want;
        gov_out.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_gap(drain_stalls_on);
            if (stall != 0) begin
                gov_out.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            gov_out.ready <= 1'b1;
            do @(posedge i_clk); while (gov_out.valid !== 1'b1);
            got.scale = gov_out.scale_now;
            got.panic = gov_out.panic_flag;
            got.load  = gov_out.load_now;
            got.dir   = gov_out.direction;
            if (pending_readings.size() == 0) begin
                $display("%0t unexpected transaction: expected none, got scale %0d panic %0b load %0d dir %0d",
                         $time, got.scale, got.panic, got.load, got.dir);
                mismatch_count++;
            end else begin
                want = pending_readings.pop_front();
                if (got.scale !== want.scale) begin
                    $display("%0t scale_now: expected %0d, got %0d", $time, want.scale, got.scale);
                    mismatch_count++;
                end
                if (got.panic !== want.panic) begin
                    $display("%0t panic_flag: expected %0b, got %0b", $time, want.panic, got.panic);
                    mismatch_count++;
                end
                if (got.load !== want.load) begin
                    $display("%0t load_now: expected %0d, got %0d", $time, want.load, got.load);
                    mismatch_count++;
                end
                if (got.dir !== want.dir) begin
                    $display("%0t direction: expected %0d, got %0d", $time, want.dir, got.dir);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : run_tests
        gov_in.valid         = 1'b0;
        gov_in.opcode        = OP_ADD_LOAD;
        gov_in.operand_value = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_TARGET_LOAD;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;

        store_setting(CFG_TARGET_LOAD, RST_TARGET_LOAD);
        store_setting(CFG_LOAD_TOLERANCE, RST_LOAD_TOLERANCE);
        store_setting(CFG_STEP_SIZE, {16'd0, RST_STEP_SIZE});
        store_setting(CFG_MIN_SCALE, {16'd0, RST_MIN_SCALE});
        store_setting(CFG_MAX_SCALE, {16'd0, RST_MAX_SCALE});
        store_setting(CFG_IDEAL_SCALE, {16'd0, RST_IDEAL_SCALE});
        store_setting(CFG_GOVERNOR_OFF, 32'd0);
        gov_scale    = RST_IDEAL_SCALE;
        gov_load     = '0;
        gov_dir      = DIR_STEADY;
        gov_panic    = 1'b0;
        gov_count_en = 1'b1;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unused_opcodes();
        test_load_counting();
        test_adjust_hysteresis();
        test_floor_and_panic();
        test_restart();
        test_down_step_above_max();
        test_inactive_governor();
        test_random_frames();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
